// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants, register codes and transaction types of the pitch
// segmenter / note extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    localparam int NUM_BUCKETS = 129;
    localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
    localparam int WINDOW_SIZE = 3;
    localparam int PAST_SLOTS  = WINDOW_SIZE - 1;
    localparam int SEEN_BITS   = $clog2(PAST_SLOTS + 1);
    localparam int COUNT_BITS  = 16;

    localparam int PITCH_W    = 16;
    localparam int NOTE_W     = 8;
    localparam int START_W    = 32;
    localparam int LEN_W      = 16;
    localparam int VEL_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_DATA_W-1:0] RANGE_THR_RESET = 16'd102;
    localparam logic [VEL_W-1:0]      DEF_VEL_RESET   = 7'd64;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_MAX         = {LEN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_THRESHOLD  = 1'b0,
        CFG_DEFAULT_VELOCITY = 1'b1
    } t_cfg_idx;

    // sample after the window stage
    typedef struct packed {
        logic                   split;
        logic                   last;
        logic                   in_range;
        logic [BUCKET_BITS-1:0] bucket;
    } t_s1_item;

    typedef struct packed {
        logic [NOTE_W-1:0]  pitch;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [VEL_W-1:0]   velocity;
        logic               end_of_run;
    } t_note;

endpackage

`default_nettype wire

// ===== hdl/pse_ram.sv =====
// ----------------------------------------------------------------------------
// pse_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 129
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pse_window.sv =====
// ----------------------------------------------------------------------------
// pse_window
// Input register and sample window: decides whether the current sample
// opens a new segment and maps it to a histogram bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_window (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [pse_pkg::PITCH_W-1:0]    i_pitch,
    input  wire logic                            i_last,
    input  wire logic [pse_pkg::CFG_DATA_W-1:0]  i_range_threshold,
    input  wire logic                            i_down_ready,
    output logic                                 o_load,
    output pse_pkg::t_s1_item                    o_item
);
    import pse_pkg::*;

    logic                      r_vld;
    logic signed [PITCH_W-1:0] r_pitch;
    logic                      r_last;
    logic signed [PITCH_W-1:0] r_past [PAST_SLOTS];
    logic [SEEN_BITS-1:0]      r_seen;

    logic                      w_accept;
    logic                      w_adv;
    logic signed [PITCH_W-1:0] w_mn;
    logic signed [PITCH_W-1:0] w_mx;
    logic [PITCH_W:0]          w_range;
    logic [PITCH_W:0]          w_diff;
    logic [PITCH_W:0]          w_adiff;
    logic [PITCH_W+2:0]        w_lhs;
    logic [PITCH_W+2:0]        w_rhs;
    logic [PITCH_W:0]          w_rsum;

    assign w_adv    = r_vld && i_down_ready;
    assign o_ready  = !r_vld || i_down_ready;
    assign w_accept = i_valid && o_ready;
    assign o_load   = w_adv;

    // min and max over the current sample and the samples already seen
    always_comb begin
        w_mn = r_pitch;
        w_mx = r_pitch;
        for (int i = 0; i < PAST_SLOTS; i++) begin
            if (SEEN_BITS'(i) < r_seen) begin
                if (r_past[i] < w_mn) w_mn = r_past[i];
                if (r_past[i] > w_mx) w_mx = r_past[i];
            end
        end
    end

    assign w_range = {w_mx[PITCH_W-1], w_mx} - {w_mn[PITCH_W-1], w_mn};
    assign w_diff  = {r_pitch[PITCH_W-1], r_pitch} - {r_past[0][PITCH_W-1], r_past[0]};
    assign w_adiff = w_diff[PITCH_W] ? (~w_diff + 1'b1) : w_diff;
    // 3*|diff| against 2*range
    assign w_lhs   = {2'b00, w_adiff} + {1'b0, w_adiff, 1'b0};
    assign w_rhs   = {1'b0, w_range, 1'b0};

    // round half away from zero; only values at or above -127 land in bucket 0 or up
    assign w_rsum  = {r_pitch[PITCH_W-1], r_pitch} + (PITCH_W+1)'(128);

    always_comb begin
        o_item.split    = (r_seen != '0) && (w_range >= {1'b0, i_range_threshold})
                          && (w_lhs > w_rhs);
        o_item.last     = r_last;
        o_item.in_range = !w_rsum[PITCH_W] && (w_rsum != '0)
                          && (w_rsum[PITCH_W:8] <= (PITCH_W-7)'(NUM_BUCKETS - 1));
        o_item.bucket   = w_rsum[8 +: BUCKET_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_seen <= '0;
            for (int i = 0; i < PAST_SLOTS; i++) begin
                r_past[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_vld <= 1'b1;
            end else if (w_adv) begin
                r_vld <= 1'b0;
            end
            if (w_adv) begin
                if (r_last) begin
                    r_seen <= '0;
                    for (int i = 0; i < PAST_SLOTS; i++) begin
                        r_past[i] <= '0;
                    end
                end else begin
                    for (int i = PAST_SLOTS - 1; i > 0; i--) begin
                        r_past[i] <= r_past[i-1];
                    end
                    r_past[0] <= r_pitch;
                    if (r_seen < SEEN_BITS'(PAST_SLOTS)) begin
                        r_seen <= r_seen + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pitch <= i_pitch;
            r_last  <= i_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pse_hist.sv =====
// ----------------------------------------------------------------------------
// pse_hist
// Histogram stage: bucket read-modify-write with forwarding, running mode,
// segment bookkeeping and note assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_hist (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire pse_pkg::t_s1_item           i_item,
    input  wire logic [pse_pkg::VEL_W-1:0]   i_default_velocity,
    input  wire logic                        i_room,
    output logic                             o_can_load,
    output logic [1:0]                       o_push_n,
    output pse_pkg::t_note                   o_note0,
    output pse_pkg::t_note                   o_note1
);
    import pse_pkg::*;

    logic                    r_vld;
    t_s1_item                r_item;
    logic                    r_fwd;
    logic [COUNT_BITS-1:0]   r_fwd_data;
    logic [NUM_BUCKETS-1:0]  r_bvalid;
    logic [BUCKET_BITS-1:0]  r_best_b;
    logic [COUNT_BITS-1:0]   r_best_cnt;
    logic [START_W-1:0]      r_seg_begin;
    logic [START_W-1:0]      r_sample_index;
    logic [LEN_W-1:0]        r_seg_samples;

    logic                    w_fire;
    logic                    w_we;
    logic [COUNT_BITS-1:0]   w_rdata;
    logic [COUNT_BITS-1:0]   w_cnt_mem;
    logic [COUNT_BITS-1:0]   w_cnt_old;
    logic [COUNT_BITS-1:0]   w_cnt_new;
    logic [BUCKET_BITS-1:0]  w_base_b;
    logic [COUNT_BITS-1:0]   w_base_cnt;
    logic                    w_take;
    logic [NUM_BUCKETS-1:0]  n_bvalid;
    logic [BUCKET_BITS-1:0]  n_best_b;
    logic [COUNT_BITS-1:0]   n_best_cnt;
    logic [START_W-1:0]      n_seg_begin;
    logic [LEN_W-1:0]        w_len_base;
    logic [LEN_W-1:0]        n_seg_samples;
    t_note                   w_note_a;
    t_note                   w_note_b;

    assign w_fire     = r_vld && i_room;
    assign o_can_load = !r_vld || w_fire;
    assign w_we       = w_fire && r_item.in_range;

    pse_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BUCKETS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_item.bucket),
        .i_wdata (w_cnt_new),
        .i_re    (i_load),
        .i_raddr (i_item.bucket),
        .o_rdata (w_rdata)
    );

    // write of the leaving transaction lands at the same edge as the read
    assign w_cnt_mem = r_fwd ? r_fwd_data : w_rdata;

    always_comb begin
        w_cnt_old  = (r_item.split || !r_bvalid[r_item.bucket]) ? '0 : w_cnt_mem;
        w_cnt_new  = (w_cnt_old == COUNT_MAX) ? COUNT_MAX : w_cnt_old + 1'b1;
        w_base_b   = r_item.split ? '0 : r_best_b;
        w_base_cnt = r_item.split ? '0 : r_best_cnt;
        // ties go to the lower bucket
        w_take     = r_item.in_range && ((w_cnt_new > w_base_cnt)
                     || ((w_cnt_new == w_base_cnt) && (r_item.bucket < w_base_b)));
        n_best_b   = w_take ? r_item.bucket : w_base_b;
        n_best_cnt = w_take ? w_cnt_new : w_base_cnt;
        n_bvalid   = r_item.split ? '0 : r_bvalid;
        if (r_item.in_range) begin
            n_bvalid[r_item.bucket] = 1'b1;
        end
        n_seg_begin   = r_item.split ? r_sample_index : r_seg_begin;
        w_len_base    = r_item.split ? '0 : r_seg_samples;
        n_seg_samples = (w_len_base == LEN_MAX) ? LEN_MAX : w_len_base + 1'b1;
    end

    always_comb begin
        w_note_a.pitch      = NOTE_W'(r_best_b);
        w_note_a.start      = r_seg_begin;
        w_note_a.length     = r_seg_samples;
        w_note_a.velocity   = (r_best_b == '0) ? '0 : i_default_velocity;
        w_note_a.end_of_run = !r_item.last;
        w_note_b.pitch      = NOTE_W'(n_best_b);
        w_note_b.start      = n_seg_begin;
        w_note_b.length     = n_seg_samples;
        w_note_b.velocity   = (n_best_b == '0) ? '0 : i_default_velocity;
        w_note_b.end_of_run = 1'b1;
    end

    assign o_note0  = r_item.split ? w_note_a : w_note_b;
    assign o_note1  = w_note_b;
    assign o_push_n = w_fire ? ({1'b0, r_item.split} + {1'b0, r_item.last}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= 1'b0;
            r_bvalid       <= '0;
            r_best_b       <= '0;
            r_best_cnt     <= '0;
            r_seg_begin    <= '0;
            r_sample_index <= '0;
            r_seg_samples  <= '0;
        end else begin
            if (i_load) begin
                r_vld <= 1'b1;
            end else if (w_fire) begin
                r_vld <= 1'b0;
            end
            if (w_fire) begin
                if (r_item.last) begin
                    r_bvalid       <= '0;
                    r_best_b       <= '0;
                    r_best_cnt     <= '0;
                    r_seg_begin    <= '0;
                    r_sample_index <= '0;
                    r_seg_samples  <= '0;
                end else begin
                    r_bvalid       <= n_bvalid;
                    r_best_b       <= n_best_b;
                    r_best_cnt     <= n_best_cnt;
                    r_seg_begin    <= n_seg_begin;
                    r_sample_index <= r_sample_index + 1'b1;
                    r_seg_samples  <= n_seg_samples;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item     <= i_item;
            r_fwd      <= w_we && (r_item.bucket == i_item.bucket);
            r_fwd_data <= w_cnt_new;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pse_outq.sv =====
// ----------------------------------------------------------------------------
// pse_outq
// Small result queue: takes up to two notes per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_outq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_push_n,
    input  wire pse_pkg::t_note i_note0,
    input  wire pse_pkg::t_note i_note1,
    output logic             o_room,
    output logic             o_valid,
    input  wire logic        i_ready,
    output pse_pkg::t_note   o_note
);
    import pse_pkg::*;

    t_note               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp;
    logic [OQ_PTR_W-1:0] r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                w_pop;
    logic [OQ_PTR_W-1:0] w_wp1;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_note  = r_mem[r_rp];
    assign w_wp1   = r_wp + 1'b1;
    // room for two more after this cycle's pop
    assign o_room  = (r_cnt <= OQ_CNT_W'(OQ_DEPTH - 2))
                     || ((r_cnt == OQ_CNT_W'(OQ_DEPTH - 1)) && w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OQ_PTR_W'(i_push_n);
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + OQ_CNT_W'(i_push_n) - OQ_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_note0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wp1] <= i_note1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pitch_segmenter_note_extractor.sv =====
// ----------------------------------------------------------------------------
// pitch_segmenter_note_extractor
// Splits a stream of Q8.8 pitch samples into segments and emits one note
// (histogram mode, start, length, velocity) per closed segment.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  sample    in         i_valid / o_ready    i_pitch, i_last
//  note      out        o_valid / i_ready    o_note_pitch, o_note_onset,
//                                            o_note_length, o_note_velocity,
//                                            o_end_of_run
//  config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
//  one sample transaction per cycle while o_ready is high; its notes pass
//  the window and histogram registers, enter the note queue and are offered
//  once queued. notes leave one per cycle while i_ready is high, so a sample
//  with two notes needs two transfers; a four-entry queue sits between.
//  synchronous active-low reset clears the bucket valid bits at once. a note
//  side stall drops o_ready once the queue can't take two and both stages hold
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_segmenter_note_extractor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [pse_pkg::PITCH_W-1:0]  i_pitch,
    input  wire logic                                i_last,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [pse_pkg::NOTE_W-1:0]               o_note_pitch,
    output logic [pse_pkg::START_W-1:0]              o_note_onset,
    output logic [pse_pkg::LEN_W-1:0]                o_note_length,
    output logic [pse_pkg::VEL_W-1:0]                o_note_velocity,
    output logic                                     o_end_of_run,
    input  wire logic                                i_cfg_we,
    input  wire logic [pse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pse_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import pse_pkg::*;

    logic [CFG_DATA_W-1:0] r_range_threshold;
    logic [VEL_W-1:0]      r_default_velocity;

    logic       w_load;
    logic       w_can_load;
    t_s1_item   w_item;
    logic       w_room;
    logic [1:0] w_push_n;
    t_note      w_note0;
    t_note      w_note1;
    t_note      w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_threshold  <= RANGE_THR_RESET;
            r_default_velocity <= DEF_VEL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RANGE_THRESHOLD:  r_range_threshold  <= i_cfg_wdata;
                CFG_DEFAULT_VELOCITY: r_default_velocity <= i_cfg_wdata[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    pse_window u_window (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pitch           (i_pitch),
        .i_last            (i_last),
        .i_range_threshold (r_range_threshold),
        .i_down_ready      (w_can_load),
        .o_load            (w_load),
        .o_item            (w_item)
    );

    pse_hist u_hist (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (w_load),
        .i_item             (w_item),
        .i_default_velocity (r_default_velocity),
        .i_room             (w_room),
        .o_can_load         (w_can_load),
        .o_push_n           (w_push_n),
        .o_note0            (w_note0),
        .o_note1            (w_note1)
    );

    pse_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_note0  (w_note0),
        .i_note1  (w_note1),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_note   (w_out)
    );

    assign o_note_pitch    = w_out.pitch;
    assign o_note_onset    = w_out.start;
    assign o_note_length   = w_out.length;
    assign o_note_velocity = w_out.velocity;
    assign o_end_of_run    = w_out.end_of_run;

endmodule

`default_nettype wire

// ===== test/pse_segment_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_segment_tracker_pkg
// Tracks segments of the pitch stream in the testbench, predicts the notes the
// segmenter owes, and checks each note transaction against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pse_segment_tracker_pkg;

    import pse_pkg::*;

    class segment_tracker;

        logic [CFG_DATA_W-1:0] spread_floor;
        logic [VEL_W-1:0]      loud_velocity;

        // newest sample first
        int                    history [PAST_SLOTS];
        int unsigned           history_len;

        logic [COUNT_BITS-1:0] hits [NUM_BUCKETS];
        bit                    hit_valid [NUM_BUCKETS];
        logic [NOTE_W-1:0]     mode_pitch;
        logic [COUNT_BITS-1:0] mode_hits;

        logic [START_W-1:0]    seg_start;
        logic [START_W-1:0]    sample_pos;
        logic [LEN_W-1:0]      seg_len;

        t_note                 notes_due [$];
        int unsigned           errors;

        function new();
            spread_floor  = RANGE_THR_RESET;
            loud_velocity = DEF_VEL_RESET;
            errors        = 0;
            end_stream();
        endfunction

        function void open_segment(logic [START_W-1:0] start);
            foreach (hit_valid[b]) hit_valid[b] = 1'b0;
            mode_pitch = '0;
            mode_hits  = '0;
            seg_start  = start;
            seg_len    = '0;
        endfunction

        function void end_stream();
            foreach (history[k]) history[k] = 0;
            history_len = 0;
            sample_pos  = '0;
            open_segment('0);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RANGE_THRESHOLD:  spread_floor  = data;
                CFG_DEFAULT_VELOCITY: loud_velocity = data[VEL_W-1:0];
                default: ;
            endcase
        endfunction

        function t_note close_note(bit eor);
            t_note n;
            n.pitch      = mode_pitch;
            n.start      = seg_start;
            n.length     = seg_len;
            n.velocity   = (mode_pitch == '0) ? '0 : loud_velocity;
            n.end_of_run = eor;
            return n;
        endfunction

        function void take_sample(logic signed [PITCH_W-1:0] pitch, logic last);
            int                    cur, lo, hi, spread, step, semis, k;
            int unsigned           b;
            logic [COUNT_BITS-1:0] c;
            bit                    split;
            cur   = pitch;
            lo    = cur;
            hi    = cur;
            split = 1'b0;
            for (k = 0; k < history_len; k++) begin
                if (history[k] < lo) lo = history[k];
                if (history[k] > hi) hi = history[k];
            end
            if (history_len > 0) begin
                step = cur - history[0];
                if (step < 0) step = -step;
                spread = hi - lo;
                split  = (spread >= int'(spread_floor)) && (3 * step > 2 * spread);
            end

            if (split) begin
                // the closed segment ends the run unless this sample ends the stream
                notes_due.push_back(close_note(!last));
                open_segment(sample_pos);
            end

            if (seg_len != LEN_MAX) seg_len++;
            // half away from zero
            semis = (cur >= 0) ? (cur + 128) / 256 : -((128 - cur) / 256);
            if (semis >= 0 && semis < NUM_BUCKETS) begin
                b = semis;
                c = hit_valid[b] ? hits[b] : '0;
                if (c != COUNT_MAX) c++;
                hits[b]      = c;
                hit_valid[b] = 1'b1;
                if (c > mode_hits || (c == mode_hits && b < mode_pitch)) begin
                    mode_hits  = c;
                    mode_pitch = NOTE_W'(b);
                end
            end

            if (last) begin
                notes_due.push_back(close_note(1'b1));
                end_stream();
            end else begin
                for (k = PAST_SLOTS - 1; k > 0; k--) history[k] = history[k-1];
                history[0] = cur;
                if (history_len < PAST_SLOTS) history_len++;
                sample_pos++;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("[%0t] %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_note(t_note got);
            t_note want;
            if (notes_due.size() == 0) begin
                errors++;
                $display("[%0t] unexpected note: pitch %0d start %0d length %0d",
                         $time, got.pitch, got.start, got.length);
                return;
            end
            want = notes_due.pop_front();
            compare_field("note_pitch", 32'(want.pitch), 32'(got.pitch));
            compare_field("note_start", want.start, got.start);
            compare_field("note_length", 32'(want.length), 32'(got.length));
            compare_field("note_velocity", 32'(want.velocity), 32'(got.velocity));
            compare_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
        endfunction

        function int unsigned pending();
            return notes_due.size();
        endfunction

        function bit clean();
            if (notes_due.size() != 0)
                $display("[%0t] %0d notes never arrived", $time, notes_due.size());
            return errors == 0 && notes_due.size() == 0;
        endfunction

    endclass

endpackage

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives pitch streams into the segmenter through both valid/ready channels,
// with random idle bursts, a long note-side hold and register changes between
// phases, and checks every note against the segment tracker's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import pse_pkg::*;
    import pse_segment_tracker_pkg::*;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic signed [PITCH_W-1:0]   i_pitch     = '0;
    logic                        i_last      = 1'b0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic [NOTE_W-1:0]           o_note_pitch;
    logic [START_W-1:0]          o_note_onset;
    logic [LEN_W-1:0]            o_note_length;
    logic [VEL_W-1:0]            o_note_velocity;
    logic                        o_end_of_run;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;

    t_note                       shown_note;
    segment_tracker              tracker;
    int unsigned                 samples_sent   = 0;
    int unsigned                 send_gap_pct   = 0;
    int unsigned                 take_stall_pct = 0;
    bit                          hold_off       = 1'b0;

    pitch_segmenter_note_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pitch         (i_pitch),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_note_pitch    (o_note_pitch),
        .o_note_onset    (o_note_onset),
        .o_note_length   (o_note_length),
        .o_note_velocity (o_note_velocity),
        .o_end_of_run    (o_end_of_run),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    assign shown_note = {o_note_pitch, o_note_onset, o_note_length, o_note_velocity,
                         o_end_of_run};

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) tracker.take_sample(i_pitch, i_last);
            if (o_valid && i_ready) tracker.check_note(shown_note);
        end
    end

    // note side: random stall bursts, or one long hold when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
                i_ready <= 1'b1;
            end else if (take_stall_pct != 0 && $urandom_range(0, 99) < take_stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic signed [PITCH_W-1:0] pitch, input logic last);
        @(negedge i_clk);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pitch <= pitch;
        i_last  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic program_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    // drop valid, wait for every note due, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // a sung line: held pitches with jitter, jumps between them, last on the end
    task automatic play_phrase(input int unsigned len);
        int          centre, jit, v;
        int unsigned held, k;
        centre = 60 * 256;
        jit    = 0;
        held   = 0;
        for (k = 0; k < len; k++) begin
            if (held == 0) begin
                case ($urandom_range(0, 9))
                    0:       centre = 0;
                    1:       centre = 128 * 256 - int'($urandom_range(0, 200));
                    2:       centre = -int'($urandom_range(1, 32768));
                    3:       centre = centre + int'($urandom_range(0, 300)) - 150;
                    default: centre = int'($urandom_range(24, 108)) * 256;
                endcase
                jit  = $urandom_range(0, 80);
                held = $urandom_range(1, 12);
            end
            v = centre + int'($urandom_range(0, 2 * jit)) - jit;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_sample(v[PITCH_W-1:0], k == len - 1);
            held--;
        end
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned first, n, k;
        first = samples_sent;
        while (samples_sent - first < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                play_phrase($urandom_range(1, 30));
            end else begin
                // raw noise, occasionally ending the stream
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_sample(PITCH_W'($urandom_range(0, 65535)),
                                $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] thr;
        logic [VEL_W-1:0]      vel;
        logic [8:0]            junk;
        int unsigned           p, k;

        tracker = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples on the reset register values
        send_sample(16'sh0000, 1'b1);    // silent one-sample stream
        send_sample(16'sh007F, 1'b0);    // just under one half rounds down
        send_sample(16'sh0080, 1'b0);    // one half rounds up
        send_sample(16'shFF81, 1'b0);    // small negative rounds to zero
        send_sample(16'shFF80, 1'b0);    // minus one half rounds away, out of range
        send_sample(16'sh7FFF, 1'b0);    // top of range lands in the highest bucket
        send_sample(16'sh7F80, 1'b0);
        send_sample(16'sh8000, 1'b0);    // most negative, full-scale jump
        send_sample(16'sh8000, 1'b1);    // segment with an empty histogram
        send_sample(16'sd15500, 1'b0);   // rounds to 61
        send_sample(16'sd15400, 1'b0);   // rounds to 60, ties go low
        send_sample(16'sd15450, 1'b0);
        send_sample(16'sd20000, 1'b1);   // split on the final sample, two notes
        settle();

        send_gap_pct   = 30;
        take_stall_pct = 30;
        program_reg(CFG_RANGE_THRESHOLD, 16'd0);
        program_reg(CFG_DEFAULT_VELOCITY, {9'h1FF, 7'd127});
        random_phase(110);
        settle();

        // jump on every sample while the note side holds off, so the block backs up
        send_gap_pct = 0;
        program_reg(CFG_RANGE_THRESHOLD, RANGE_THR_RESET);
        hold_off = 1'b1;
        for (k = 0; k < 40; k++)
            send_sample((k % 2) ? 16'sd23040 : 16'sd10240, k == 39);
        settle();

        for (p = 0; p < 6; p++) begin
            case (p)
                0:       thr = 16'hFFFF;
                1:       thr = CFG_DATA_W'($urandom_range(0, 400));
                2:       thr = RANGE_THR_RESET;
                3:       thr = CFG_DATA_W'($urandom_range(0, 65535));
                4:       thr = CFG_DATA_W'($urandom_range(100, 3000));
                default: thr = 16'd0;
            endcase
            vel  = (p == 0) ? 7'd0 : 7'($urandom_range(0, 127));
            junk = 9'($urandom);
            program_reg(CFG_RANGE_THRESHOLD, thr);
            program_reg(CFG_DEFAULT_VELOCITY, {junk, vel});
            send_gap_pct   = 15 * $urandom_range(0, 3);
            take_stall_pct = 15 * $urandom_range(0, 3);
            random_phase(100);
            settle();
        end

        // one steady held note with no jitter
        send_gap_pct   = 0;
        take_stall_pct = 0;
        for (k = 0; k < 20; k++)
            send_sample(16'sd17664, k == 19);
        settle();

        program_reg(CFG_RANGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 600)));
        program_reg(CFG_DEFAULT_VELOCITY, CFG_DATA_W'($urandom_range(0, 65535)));
        random_phase(90);
        settle();
        repeat (20) @(posedge i_clk);

        if (tracker.clean()) begin
            $display("pitch_segmenter_note_extractor verification clean");
        end else begin
            $display("pitch_segmenter_note_extractor verification failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("pitch_segmenter_note_extractor verification failed");
        $finish;
    end

endmodule
